FILE: rtl/ucw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the cell width lookup for the UTF-8 width decoder
package ucw_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    localparam logic [1:0] CW_ZERO = 2'd0;
    localparam logic [1:0] CW_ONE  = 2'd1;
    localparam logic [1:0] CW_TWO  = 2'd2;

    typedef logic [20:0] cp_t;

    localparam cp_t CP_MIN3  = 21'h000800;
    localparam cp_t CP_MIN4  = 21'h010000;
    localparam cp_t SURR_LO  = 21'h00D800;
    localparam cp_t SURR_HI  = 21'h00DFFF;
    localparam cp_t CP_MAX   = 21'h10FFFF;
    localparam cp_t CTRL_END = 21'h000020;
    localparam cp_t DEL_LO   = 21'h00007F;
    localparam cp_t C1_END   = 21'h0000A0;

    typedef struct packed {
        cp_t lo;
        cp_t hi;
    } span_t;

    localparam int N_ZERO = 7;
    localparam int N_WIDE = 12;

    localparam span_t ZERO_SPANS [N_ZERO] = '{
        '{21'h00300, 21'h0036F}, '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF},
        '{21'h020D0, 21'h020FF}, '{21'h0FE00, 21'h0FE0F}, '{21'h0FE20, 21'h0FE2F},
        '{21'hE0100, 21'hE01EF}
    };

    localparam span_t WIDE_SPANS [N_WIDE] = '{
        '{21'h01100, 21'h0115F}, '{21'h02329, 21'h0232A}, '{21'h02E80, 21'h0303E},
        '{21'h03040, 21'h0A4CF}, '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF},
        '{21'h0FE10, 21'h0FE19}, '{21'h0FE30, 21'h0FE6F}, '{21'h0FF00, 21'h0FF60},
        '{21'h0FFE0, 21'h0FFE6}, '{21'h1F300, 21'h1FAFF}, '{21'h20000, 21'h3FFFD}
    };

    typedef struct packed {
        logic [2:0][7:0] err_byte;
        logic [1:0]      err_cnt;
        logic            has_last;
        cp_t             last_cp;
        logic            last_err;
        logic [2:0]      last_used;
        logic            end_flag;
    } job_t;

    function automatic logic [1:0] cells_of(input cp_t cp);
        logic zero_hit;
        logic wide_hit;
        zero_hit = (cp < CTRL_END) || (cp >= DEL_LO && cp < C1_END);
        wide_hit = 1'b0;
        for (int i = 0; i < N_ZERO; i++)
        begin
            zero_hit = zero_hit || (cp >= ZERO_SPANS[i].lo && cp <= ZERO_SPANS[i].hi);
        end
        for (int i = 0; i < N_WIDE; i++)
        begin
            wide_hit = wide_hit || (cp >= WIDE_SPANS[i].lo && cp <= WIDE_SPANS[i].hi);
        end
        if (zero_hit)
            return CW_ZERO;
        else if (wide_hit)
            return CW_TWO;
        else
            return CW_ONE;
    endfunction

endpackage

FILE: rtl/ucw_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the pending sequence and builds result jobs
module ucw_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          end_of_range,
    input  logic          q_full,
    output logic          push,
    output ucw_pkg::job_t push_job
);
    import ucw_pkg::*;

    logic [2:0]      exp_reg;
    logic [2:0]      exp_next;
    logic [1:0]      hc_reg;
    logic [1:0]      hc_next;
    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] held_next;
    logic            accept;
    logic            pending;
    logic            cont;
    logic            fin;
    logic            take_lead;
    logic [2:0]      lead_len;
    cp_t             v;
    logic            bad;
    job_t            job;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign pending  = (exp_reg != LEN_NONE) && (hc_reg != 2'd0);
    assign cont     = (data_byte[7:6] == 2'b10);
    assign fin      = (({1'b0, hc_reg} + 3'd1) >= exp_reg);

    always_comb
    begin
        if (data_byte <= ASCII_MAX)
            lead_len = LEN_1;
        else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI)
            lead_len = LEN_2;
        else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI)
            lead_len = LEN_3;
        else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI)
            lead_len = LEN_4;
        else
            lead_len = LEN_NONE;
    end

    always_comb
    begin
        unique case (exp_reg)
            LEN_2:   v = {10'd0, held_reg[0][4:0], data_byte[5:0]};
            LEN_3:   v = {5'd0, held_reg[0][3:0], held_reg[1][5:0], data_byte[5:0]};
            LEN_4:   v = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                          data_byte[5:0]};
            default: v = '0;
        endcase
    end

    assign bad = (exp_reg == LEN_3 && v < CP_MIN3) || (exp_reg == LEN_4 && v < CP_MIN4) ||
                 (v >= SURR_LO && v <= SURR_HI) || (v > CP_MAX);

    always_comb
    begin
        exp_next       = exp_reg;
        hc_next        = hc_reg;
        held_next      = held_reg;
        take_lead      = 1'b1;
        job.err_byte   = held_reg;
        job.err_cnt    = 2'd0;
        job.has_last   = 1'b0;
        job.last_cp    = {13'd0, data_byte};
        job.last_err   = 1'b1;
        job.last_used  = LEN_1;
        job.end_flag   = end_of_range;
        if (pending)
        begin
            if (cont)
            begin
                take_lead = 1'b0;
                if (fin)
                begin
                    exp_next     = LEN_NONE;
                    hc_next      = 2'd0;
                    job.has_last = 1'b1;
                    if (bad)
                    begin
                        job.err_cnt = hc_reg;
                    end
                    else
                    begin
                        job.last_cp   = v;
                        job.last_err  = 1'b0;
                        job.last_used = exp_reg;
                    end
                end
                else
                begin
                    held_next[hc_reg] = data_byte;
                    hc_next           = hc_reg + 2'd1;
                    if (end_of_range)
                    begin
                        job.err_cnt  = hc_reg;
                        job.has_last = 1'b1;
                    end
                end
            end
            else
            begin
                job.err_cnt = hc_reg;
                exp_next    = LEN_NONE;
                hc_next     = 2'd0;
            end
        end
        else
        begin
            exp_next = LEN_NONE;
            hc_next  = 2'd0;
        end
        if (take_lead)
        begin
            if (lead_len == LEN_1)
            begin
                job.has_last = 1'b1;
                job.last_err = 1'b0;
            end
            else if (lead_len == LEN_NONE || end_of_range)
            begin
                job.has_last = 1'b1;
            end
            else
            begin
                held_next[0] = data_byte;
                hc_next      = 2'd1;
                exp_next     = lead_len;
            end
        end
        if (end_of_range)
        begin
            exp_next = LEN_NONE;
            hc_next  = 2'd0;
        end
    end

    assign push     = accept && (job.err_cnt != 2'd0 || job.has_last);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= LEN_NONE;
            hc_reg  <= 2'd0;
        end
        else if (accept)
        begin
            exp_reg <= exp_next;
            hc_reg  <= hc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    a_pending_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg == LEN_NONE) == (hc_reg == 2'd0))
        else $error("expected length and held count disagree");

    a_held_short: assert property (@(posedge clk) disable iff (!rst_n)
        pending |-> ({1'b0, hc_reg} < exp_reg))
        else $error("held bytes reach expected length");

endmodule

FILE: rtl/ucw_queue.sv
`timescale 1ns / 1ps
// Job queue between the front end and the result sequencer
module ucw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ucw_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output ucw_pkg::job_t pop_job,
    output logic          q_valid
);
    import ucw_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job popped from an empty queue");

endmodule

FILE: rtl/ucw_back.sv
`timescale 1ns / 1ps
// Back end: expands jobs into result words and keeps the running width total
module ucw_back #(
    parameter int TOTAL_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ucw_pkg::job_t q_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [20:0]   code_point,
    output logic          is_error,
    output logic [2:0]    bytes_used,
    output logic [1:0]    cell_width,
    output logic [31:0]   width_total,
    output logic          run_last,
    output logic          range_done
);
    import ucw_pkg::*;

    localparam int SUM_W = TOTAL_BITS + 1;

    job_t                  cur_reg;
    logic [1:0]            cur_w_reg;
    logic                  cur_valid_reg;
    logic [1:0]            idx_reg;
    logic [TOTAL_BITS-1:0] rw_reg;
    logic [TOTAL_BITS-1:0] rw_sat;
    logic [SUM_W-1:0]      sum;
    logic [2:0]            total;
    logic                  final_item;
    logic                  advance;
    cp_t                   item_cp;
    logic                  item_err;
    logic [2:0]            item_used;
    logic [1:0]            item_w;

    logic                  out_valid_reg;
    cp_t                   cp_reg;
    logic                  err_reg;
    logic [2:0]            used_reg;
    logic [1:0]            w_reg;
    logic [TOTAL_BITS-1:0] wt_reg;
    logic                  last_reg;
    logic                  done_reg;

    assign total      = {1'b0, cur_reg.err_cnt} + {2'b0, cur_reg.has_last};
    assign final_item = (({1'b0, idx_reg} + 3'd1) == total);
    assign advance    = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign pop        = q_valid && (!cur_valid_reg || (advance && final_item));

    always_comb
    begin
        if (idx_reg < cur_reg.err_cnt)
        begin
            item_cp   = {13'd0, cur_reg.err_byte[idx_reg]};
            item_err  = 1'b1;
            item_used = LEN_1;
            item_w    = CW_ONE;
        end
        else
        begin
            item_cp   = cur_reg.last_cp;
            item_err  = cur_reg.last_err;
            item_used = cur_reg.last_used;
            item_w    = cur_reg.last_err ? CW_ONE : cur_w_reg;
        end
    end

    assign sum    = {1'b0, rw_reg} + SUM_W'(item_w);
    assign rw_sat = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            rw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (advance)
            begin
                if (final_item)
                begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            if (advance)
                rw_reg <= (final_item && cur_reg.end_flag) ? '0 : rw_sat;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg   <= q_job;
            cur_w_reg <= cells_of(q_job.last_cp);
        end
        if (advance)
        begin
            cp_reg   <= item_cp;
            err_reg  <= item_err;
            used_reg <= item_used;
            w_reg    <= item_w;
            wt_reg   <= rw_sat;
            last_reg <= final_item;
            done_reg <= final_item && cur_reg.end_flag;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = cp_reg;
    assign is_error    = err_reg;
    assign bytes_used  = used_reg;
    assign cell_width  = w_reg;
    assign width_total = 32'(wt_reg);
    assign run_last    = last_reg;
    assign range_done  = done_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (total != 3'd0 && {1'b0, idx_reg} < total))
        else $error("result index outside current job");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("range end flagged on a word that is not the last of its byte");

endmodule

FILE: rtl/utf8_decode_cell_width.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 decoder with terminal cell width
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | input     | in_valid / in_stall  | data_byte, end_of_range
//  out      | output    | out_valid / out_stall| code_point, is_error, bytes_used,
//           |           |                      | cell_width, width_total, run_last,
//           |           |                      | range_done
//
// One byte is accepted per cycle while the job queue has room; the output word is registered.
// The sequencer sends one word per cycle while out_stall is low and ends a job before the next.
// A four-entry job queue between front end and sequencer absorbs error bursts.
// Reset clears the pending sequence, the queue and the width total; no clearing pass.
// out_stall holds the output word; in_stall rises only when the job queue is full.
module utf8_decode_cell_width #(
    parameter int TOTAL_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_range,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic        is_error,
    output logic [2:0]  bytes_used,
    output logic [1:0]  cell_width,
    output logic [31:0] width_total,
    output logic        run_last,
    output logic        range_done
);
    import ucw_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic q_valid;
    job_t push_job;
    job_t pop_job;

    ucw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_range (end_of_range),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    ucw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_valid  (q_valid)
    );

    ucw_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (pop_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .is_error    (is_error),
        .bytes_used  (bytes_used),
        .cell_width  (cell_width),
        .width_total (width_total),
        .run_last    (run_last),
        .range_done  (range_done)
    );

endmodule

FILE: tb/utf8_decode_cell_width_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 decoder with terminal cell width
module utf8_decode_cell_width_tb;

    import ucw_pkg::*;

    localparam logic [63:0] TOTAL_CAP = 64'hFFFF_FFFF;
    localparam int DIRECTED_BYTES = 29;
    localparam int RANDOM_BYTES = 80;

    typedef struct {
        logic [20:0] cp;
        logic        err;
        logic [2:0]  used;
        logic [1:0]  cw;
        logic [31:0] total;
        logic        last;
        logic        done;
    } glyph_word_t;

    class width_scoreboard;
        logic [2:0]  want_len;
        logic [1:0]  held_n;
        logic [7:0]  held [3];
        logic [63:0] sum;
        glyph_word_t burst [$];
        glyph_word_t due [$];
        int          fails;

        function new();
            want_len = LEN_NONE;
            held_n = 0;
            sum = 0;
            fails = 0;
        endfunction

        function logic [1:0] columns(input logic [20:0] cp);
            if (cp < CTRL_END || (cp >= DEL_LO && cp < C1_END))
                return CW_ZERO;
            if (cp inside {[21'h00300:21'h0036F], [21'h01AB0:21'h01AFF], [21'h01DC0:21'h01DFF],
                           [21'h020D0:21'h020FF], [21'h0FE00:21'h0FE0F], [21'h0FE20:21'h0FE2F],
                           [21'hE0100:21'hE01EF]})
                return CW_ZERO;
            if (cp inside {[21'h01100:21'h0115F], [21'h02329:21'h0232A], [21'h02E80:21'h0303E],
                           [21'h03040:21'h0A4CF], [21'h0AC00:21'h0D7A3], [21'h0F900:21'h0FAFF],
                           [21'h0FE10:21'h0FE19], [21'h0FE30:21'h0FE6F], [21'h0FF00:21'h0FF60],
                           [21'h0FFE0:21'h0FFE6], [21'h1F300:21'h1FAFF], [21'h20000:21'h3FFFD]})
                return CW_TWO;
            return CW_ONE;
        endfunction

        function void push(input logic [20:0] cp, input logic err, input logic [2:0] used,
                           input logic [1:0] cw);
            glyph_word_t w;
            if (burst.size() >= 4)
                return;
            if (sum > TOTAL_CAP || TOTAL_CAP - sum < 64'(cw))
                sum = TOTAL_CAP;
            else
                sum = sum + 64'(cw);
            w.cp = cp;
            w.err = err;
            w.used = used;
            w.cw = cw;
            w.total = sum[31:0];
            w.last = 1'b0;
            w.done = 1'b0;
            burst.push_back(w);
        endfunction

        function void flush();
            for (int i = 0; i < held_n; i++)
                push({13'b0, held[i]}, 1'b1, LEN_1, CW_ONE);
            held_n = 0;
            want_len = LEN_NONE;
        endfunction

        function void lead(input logic [7:0] b, input logic e);
            logic [2:0] len;
            len = LEN_NONE;
            if (b <= ASCII_MAX)
            begin
                push({13'b0, b}, 1'b0, LEN_1, columns({13'b0, b}));
                return;
            end
            if (b >= LEAD2_LO && b <= LEAD2_HI)
                len = LEN_2;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
                len = LEN_3;
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
                len = LEN_4;
            if (len == LEN_NONE || e)
            begin
                push({13'b0, b}, 1'b1, LEN_1, CW_ONE);
                return;
            end
            held[0] = b;
            held_n = 1;
            want_len = len;
        endfunction

        function void complete(input logic [7:0] b);
            logic [31:0] v;
            logic bad;
            if (want_len == LEN_2)
                v = {27'b0, held[0][4:0]};
            else if (want_len == LEN_3)
                v = {28'b0, held[0][3:0]};
            else
                v = {29'b0, held[0][2:0]};
            for (int i = 1; i < held_n; i++)
                v = (v << 6) | {26'b0, held[i][5:0]};
            v = (v << 6) | {26'b0, b[5:0]};
            bad = (want_len == LEN_3 && v < 32'(CP_MIN3)) ||
                  (want_len == LEN_4 && v < 32'(CP_MIN4)) ||
                  (v >= 32'(SURR_LO) && v <= 32'(SURR_HI)) || v > 32'(CP_MAX);
            if (bad)
            begin
                flush();
                push({13'b0, b}, 1'b1, LEN_1, CW_ONE);
            end
            else
            begin
                push(v[20:0], 1'b0, want_len, columns(v[20:0]));
            end
            held_n = 0;
            want_len = LEN_NONE;
        endfunction

        function void note_input(input logic [7:0] b, input logic e);
            burst.delete();
            if (want_len != LEN_NONE && held_n != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    if (int'(held_n) + 1 >= int'(want_len))
                        complete(b);
                    else
                    begin
                        held[held_n] = b;
                        held_n = held_n + 1;
                        if (e)
                            flush();
                    end
                end
                else
                begin
                    flush();
                    lead(b, e);
                end
            end
            else
            begin
                want_len = LEN_NONE;
                held_n = 0;
                lead(b, e);
            end
            if (burst.size() > 0)
            begin
                burst[burst.size() - 1].last = 1'b1;
                burst[burst.size() - 1].done = e;
            end
            foreach (burst[i])
                due.push_back(burst[i]);
            if (e)
            begin
                sum = 0;
                want_len = LEN_NONE;
                held_n = 0;
            end
        endfunction

        function void check(input glyph_word_t got);
            glyph_word_t exp_w;
            if (due.size() == 0)
            begin
                $error("unexpected word: code_point %h", got.cp);
                fails++;
                return;
            end
            exp_w = due.pop_front();
            if (got.cp !== exp_w.cp)
            begin
                $error("code_point expected %h got %h", exp_w.cp, got.cp);
                fails++;
            end
            if (got.err !== exp_w.err)
            begin
                $error("is_error expected %b got %b", exp_w.err, got.err);
                fails++;
            end
            if (got.used !== exp_w.used)
            begin
                $error("bytes_used expected %0d got %0d", exp_w.used, got.used);
                fails++;
            end
            if (got.cw !== exp_w.cw)
            begin
                $error("cell_width expected %0d got %0d", exp_w.cw, got.cw);
                fails++;
            end
            if (got.total !== exp_w.total)
            begin
                $error("width_total expected %0d got %0d", exp_w.total, got.total);
                fails++;
            end
            if (got.last !== exp_w.last)
            begin
                $error("run_last expected %b got %b", exp_w.last, got.last);
                fails++;
            end
            if (got.done !== exp_w.done)
            begin
                $error("range_done expected %b got %b", exp_w.done, got.done);
                fails++;
            end
        endfunction

        function void flag_leftover();
            if (due.size() != 0)
            begin
                $error("%0d expected words never arrived", due.size());
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_range;
    logic        out_valid;
    logic        out_stall;
    logic [20:0] code_point;
    logic        is_error;
    logic [2:0]  bytes_used;
    logic [1:0]  cell_width;
    logic [31:0] width_total;
    logic        run_last;
    logic        range_done;

    width_scoreboard sb;
    int   sent;
    logic calm;

    utf8_decode_cell_width u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_range (end_of_range),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .is_error     (is_error),
        .bytes_used   (bytes_used),
        .cell_width   (cell_width),
        .width_total  (width_total),
        .run_last     (run_last),
        .range_done   (range_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        glyph_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            w.cp = code_point;
            w.err = is_error;
            w.used = bytes_used;
            w.cw = cell_width;
            w.total = width_total;
            w.last = run_last;
            w.done = range_done;
            sb.check(w);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(20, 50);
    endfunction

    initial
    begin : out_side
        int hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (calm || $urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b0;
                hold_left = $urandom_range(0, 8);
            end
            else
            begin
                out_stall <= 1'b1;
                if ($urandom_range(0, 99) < 85)
                    hold_left = $urandom_range(0, 2);
                else
                    hold_left = $urandom_range(10, 30);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_range <= e;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(b, e);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_run(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3, input int n, input logic fin);
        logic [7:0] seq [4];
        seq[0] = b0;
        seq[1] = b1;
        seq[2] = b2;
        seq[3] = b3;
        for (int i = 0; i < n; i++)
            send_byte(seq[i], fin && (i == n - 1));
    endtask

    task automatic send_scalar();
        logic [20:0] cp;
        logic [7:0]  seq [4];
        int          n;
        int          cut;
        logic        fin;
        case ($urandom_range(0, 5))
            0: cp = 21'($urandom_range(0, 21'h7F));
            1: cp = 21'($urandom_range(21'h80, 21'h7FF));
            2:
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp - 21'h800;
            end
            3: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            4:
                case ($urandom_range(0, 3))
                    0: cp = 21'h00300 + 21'($urandom_range(0, 21'h6F));
                    1: cp = 21'hE0100 + 21'($urandom_range(0, 21'hEF));
                    2: cp = 21'h0FE00 + 21'($urandom_range(0, 21'h7F));
                    default: cp = 21'h020D0 + 21'($urandom_range(0, 21'h2F));
                endcase
            default:
                case ($urandom_range(0, 3))
                    0: cp = 21'h0AC00 + 21'($urandom_range(0, 21'h2BFF));
                    1: cp = 21'h1F300 + 21'($urandom_range(0, 21'h7FF));
                    2: cp = 21'h20000 + 21'($urandom_range(0, 21'h1FFFF));
                    default: cp = 21'h01100 + 21'($urandom_range(0, 21'h5F));
                endcase
        endcase
        if (cp < 21'h80)
        begin
            n = 1;
            seq[0] = cp[7:0];
        end
        else if (cp < CP_MIN3)
        begin
            n = 2;
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
        end
        else if (cp < CP_MIN4)
        begin
            n = 3;
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            n = 4;
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
        end
        fin = ($urandom_range(0, 5) == 0);
        if (n > 1 && $urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, n - 1);
            fin = ($urandom_range(0, 2) == 0);
            send_run(seq[0], seq[1], seq[2], seq[3], cut, fin);
        end
        else
            send_run(seq[0], seq[1], seq[2], seq[3], n, fin);
    endtask

    initial
    begin : stimulus
        int waited;
        int r;
        sb = new();
        sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        end_of_range = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_run(8'h00, 8'h00, 8'h00, 8'h00, 1, 1'b0);
        send_run(8'h7F, 8'h00, 8'h00, 8'h00, 1, 1'b0);
        send_run(8'hC2, 8'hA0, 8'h00, 8'h00, 2, 1'b0);
        send_run(8'hE0, 8'hA0, 8'h80, 8'h00, 3, 1'b0);
        send_run(8'hED, 8'hA0, 8'h80, 8'h00, 3, 1'b0);
        send_run(8'hF4, 8'h8F, 8'hBF, 8'hBF, 4, 1'b1);
        send_run(8'hF4, 8'h90, 8'h80, 8'h80, 4, 1'b0);
        send_run(8'hF0, 8'h8F, 8'hBF, 8'hBF, 4, 1'b0);
        send_run(8'h80, 8'h00, 8'h00, 8'h00, 1, 1'b0);
        send_run(8'hFF, 8'h00, 8'h00, 8'h00, 1, 1'b0);
        send_run(8'hE4, 8'h41, 8'h00, 8'h00, 2, 1'b0);
        send_run(8'hF0, 8'h90, 8'h80, 8'h00, 3, 1'b1);

        while (sent < DIRECTED_BYTES + RANDOM_BYTES)
        begin
            calm = (sent >= DIRECTED_BYTES + 45 && sent < DIRECTED_BYTES + 70);
            r = $urandom_range(0, 99);
            if (r < 60)
                send_scalar();
            else if (r < 80)
                send_run(8'($urandom_range(8'hC0, 8'hFF)), 8'($urandom_range(8'h80, 8'hBF)),
                         8'($urandom_range(8'h80, 8'hBF)), 8'($urandom_range(8'h80, 8'hBF)),
                         $urandom_range(2, 4), $urandom_range(0, 3) == 0);
            else
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (sb.due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        sb.flag_leftover();
        if (sb.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
